// ===== rtl/core/gea_pkg.sv =====
// ---------------------------------------------------------------------------
// gea_pkg
// shared types and constants for the gamepad edge and auto-repeat block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gea_pkg;

    // default number of pad ports
    localparam int PORTS_DEFAULT = 4;

    // payload widths
    localparam int PORT_W   = 2;
    localparam int BTN_W    = 16;
    localparam int AXIS_W   = 8;
    localparam int DIR_W    = 4;
    localparam int THR_W    = 7;
    localparam int HOLD_W   = 32;
    localparam int CFG_W    = 16;
    localparam int IN_DW    = 40;
    localparam int OUT_DW   = 80;

    // frame accumulators
    localparam int SUM_W    = 24;
    localparam int CNT_W    = 16;

    // shared divider
    localparam int DVD_W    = 32;
    localparam int DSR_W    = 16;

    // register reset values
    localparam logic [BTN_W-1:0] MASK_RST   = 16'hFFFF;
    localparam logic [THR_W-1:0] THR_RST    = 7'd50;
    localparam logic [CFG_W-1:0] DELAY_RST  = 16'd20;
    localparam logic [CFG_W-1:0] PERIOD_RST = 16'd5;

    // register indexes
    typedef enum logic [1:0] {
        CFG_BUTTON_MASK     = 2'd0,
        CFG_STICK_THRESHOLD = 2'd1,
        CFG_REPEAT_DELAY    = 2'd2,
        CFG_REPEAT_PERIOD   = 2'd3
    } cfg_idx_t;

    // per-port state word held in the port memory
    typedef struct packed {
        logic              dead;
        logic [BTN_W-1:0]  buttons;
        logic [DIR_W-1:0]  dir;
        logic [HOLD_W-1:0] hold;
    } port_entry_t;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DSR_W-1:0] remainder;
    } div_rsp_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK,
        ST_EVAL,
        ST_MOD,
        ST_PORT_OUT,
        ST_AVG,
        ST_AVG_X,
        ST_AVG_Y,
        ST_SUM_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/gea_ram.sv =====
// ---------------------------------------------------------------------------
// gea_ram
// generic single write, single read memory with registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gea_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/gea_divider.sv =====
// ---------------------------------------------------------------------------
// gea_divider
// unsigned restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gea_divider
    import gea_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int STEP_W = $clog2(DVD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [DSR_W-1:0]  rem_reg;
    logic [DSR_W-1:0]  dsr_reg;

    logic [DSR_W:0]    shifted;
    logic              ge;
    logic [DSR_W:0]    diff;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DVD_W-1]};
        ge      = (shifted >= {1'b0, dsr_reg});
        diff    = shifted - {1'b0, dsr_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/core/gamepad_edge_and_autorepeat.sv =====
// ---------------------------------------------------------------------------
// gamepad_edge_and_autorepeat
// per-port button and stick edge detection with auto-repeat and frame summary
// ---------------------------------------------------------------------------
// usage
//   s_axis carries one poll sample per transaction: tdata holds port, raw
//   buttons and the two signed stick axes, tuser the poll error flag, tlast
//   marks the last sample of a frame
//   m_axis carries results: one per in-range port sample, plus one combined
//   result (tuser high) after a sample with tlast
//   cfg_we/cfg_index/cfg_data write the four control registers, idle only
// timing
//   a per-port result is loaded after its sample has passed the lookup and
//   eval states, and the next sample can be accepted once the sequencer is
//   back in idle; a held, unchanged input past the repeat delay adds one pass
//   of the shared 32-step divider for the period check
//   the frame summary is loaded after the last per-port result, once two
//   divider passes for the stick averages are done, or without them when
//   no port was active
//   per-port state lives in a memory with registered read data; one sample is
//   in flight at a time, so read and write-back never overlap
// reset
//   all ports connected, previous state and hold counts zero via per-entry
//   valid bits, accumulators and averages zero, registers to defaults
// stalls
//   the result register frees s_axis from m_axis; the sequencer waits only
//   when it must load a new result while the previous one is not taken
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gamepad_edge_and_autorepeat
    import gea_pkg::*;
#(
    parameter int PORTS = PORTS_DEFAULT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    // poll samples
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // port[1:0], raw_buttons[17:2], axis_x[25:18], axis_y[33:26], zero pad
    input  wire logic [IN_DW-1:0]  s_axis_tdata,
    // poll_error
    input  wire logic              s_axis_tuser,
    input  wire logic              s_axis_tlast,

    // results
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // port_out[1:0], held_buttons[17:2], pressed_buttons[33:18],
    // released_buttons[49:34], direction[53:50], direction_pressed[57:54],
    // direction_released[61:58], repeat_pulse[62], stick_x_out[70:63],
    // stick_y_out[78:71], disconnected[79]
    output logic [OUT_DW-1:0]      m_axis_tdata,
    // is_shared
    output logic                   m_axis_tuser,

    // configuration
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    localparam int ADDR_W  = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int ENTRY_W = $bits(port_entry_t);

    // ---------------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------------
    logic [BTN_W-1:0] mask_reg;
    logic [THR_W-1:0] thr_reg;
    logic [CFG_W-1:0] delay_reg;
    logic [CFG_W-1:0] period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= MASK_RST;
            thr_reg    <= THR_RST;
            delay_reg  <= DELAY_RST;
            period_reg <= PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_BUTTON_MASK:     mask_reg   <= cfg_data;
                CFG_STICK_THRESHOLD: thr_reg    <= cfg_data[THR_W-1:0];
                CFG_REPEAT_DELAY:    delay_reg  <= cfg_data;
                CFG_REPEAT_PERIOD:   period_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // sequencer state and captured sample
    // ---------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [PORT_W-1:0] port_reg;
    logic              err_reg;
    logic [BTN_W-1:0]  raw_reg;
    logic [AXIS_W-1:0] ax_reg;
    logic [AXIS_W-1:0] ay_reg;
    logic              last_reg;

    logic              in_acc;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    logic [ADDR_W-1:0] addr;
    logic              port_ok;
    assign addr    = ADDR_W'(port_reg);
    assign port_ok = ({30'd0, port_reg} < 32'(PORTS));

    // ---------------------------------------------------------------------
    // port state memory, entries read as zero until first written
    // ---------------------------------------------------------------------
    logic              ram_we;
    port_entry_t       ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [PORTS-1:0]  valid_reg;

    gea_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PORTS)
    ) u_port_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (ram_wdata),
        .raddr (ADDR_W'(s_axis_tdata[1:0])),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------------
    // shared divider: repeat period check and stick averages
    // ---------------------------------------------------------------------
    div_req_t div_req;
    div_rsp_t div_rsp;

    gea_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---------------------------------------------------------------------
    // lookup stage: edges, direction bits and hold counter increment
    // ---------------------------------------------------------------------
    port_entry_t       entry;
    logic              live;
    logic [BTN_W-1:0]  held;
    logic [DIR_W-1:0]  dir;
    logic signed [8:0] ax9, ay9, thr9;
    logic              hold_cond;

    always_comb
    begin
        entry = (port_ok && valid_reg[addr]) ? port_entry_t'(ram_rdata) : '0;
        live  = port_ok && !entry.dead && !err_reg;
        held  = raw_reg & mask_reg;
        ax9   = {ax_reg[AXIS_W-1], ax_reg};
        ay9   = {ay_reg[AXIS_W-1], ay_reg};
        thr9  = {2'b00, thr_reg};
        dir   = '0;
        // bit0 left, bit1 right, bit2 down, bit3 up
        if (ax9 < -thr9)
        begin
            dir[0] = 1'b1;
        end
        else if (ax9 > thr9)
        begin
            dir[1] = 1'b1;
        end
        if (ay9 < -thr9)
        begin
            dir[2] = 1'b1;
        end
        else if (ay9 > thr9)
        begin
            dir[3] = 1'b1;
        end
        hold_cond = ((held != '0) || (dir != '0))
                    && (held == entry.buttons) && (dir == entry.dir);
    end

    // registered lookup results
    port_entry_t       entry_reg;
    logic              live_reg;
    logic [BTN_W-1:0]  held_reg;
    logic [BTN_W-1:0]  pressed_reg;
    logic [BTN_W-1:0]  released_reg;
    logic [DIR_W-1:0]  dir_reg;
    logic [DIR_W-1:0]  dir_p_reg;
    logic [DIR_W-1:0]  dir_r_reg;
    logic              hold_cond_reg;
    logic [HOLD_W-1:0] cnt_reg;
    logic              pulse_reg;

    // eval stage: distance past the repeat delay
    logic [HOLD_W:0]   past_delay;
    logic [DSR_W-1:0]  period_eff;
    assign past_delay = {1'b0, cnt_reg} - {17'd0, delay_reg};
    assign period_eff = (period_reg == '0) ? DSR_W'(1) : period_reg;

    // ---------------------------------------------------------------------
    // frame accumulators
    // ---------------------------------------------------------------------
    logic [BTN_W-1:0]  or_held_reg, or_pressed_reg, or_released_reg;
    logic [DIR_W-1:0]  or_dir_reg, or_dir_p_reg, or_dir_r_reg;
    logic              or_pulse_reg;
    logic [SUM_W-1:0]  sum_x_reg, sum_y_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [AXIS_W-1:0] avg_x_reg, avg_y_reg;

    logic [SUM_W-1:0]  mag_x, mag_y;
    logic [AXIS_W-1:0] quo8;
    assign mag_x = sum_x_reg[SUM_W-1] ? (~sum_x_reg + 1'b1) : sum_x_reg;
    assign mag_y = sum_y_reg[SUM_W-1] ? (~sum_y_reg + 1'b1) : sum_y_reg;
    assign quo8  = div_rsp.quotient[AXIS_W-1:0];

    // ---------------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------------
    logic              out_valid_reg;
    logic [OUT_DW-1:0] out_data_reg;
    logic              out_user_reg;
    logic              slot_free;
    logic              load_port;
    logic              load_shared;

    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // ---------------------------------------------------------------------
    // next state and control
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        div_req.start    = 1'b0;
        div_req.dividend = past_delay[DVD_W-1:0];
        div_req.divisor  = period_eff;
        load_port        = 1'b0;
        load_shared      = 1'b0;
        ram_we           = 1'b0;
        if (live_reg)
        begin
            ram_wdata = '{dead: 1'b0, buttons: held_reg, dir: dir_reg,
                          hold: hold_cond_reg ? cnt_reg : '0};
        end
        else
        begin
            ram_wdata = '{dead: 1'b1, buttons: entry_reg.buttons,
                          dir: entry_reg.dir, hold: entry_reg.hold};
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (live_reg && hold_cond_reg && !past_delay[HOLD_W])
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_MOD;
                end
                else if (port_ok)
                begin
                    state_next = ST_PORT_OUT;
                end
                else if (last_reg)
                begin
                    state_next = ST_AVG;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MOD:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_PORT_OUT;
                end
            end
            ST_PORT_OUT:
            begin
                if (slot_free)
                begin
                    load_port  = 1'b1;
                    ram_we     = 1'b1;
                    state_next = last_reg ? ST_AVG : ST_IDLE;
                end
            end
            ST_AVG:
            begin
                if (count_reg == '0)
                begin
                    if (slot_free)
                    begin
                        load_shared = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DVD_W'(mag_x);
                    div_req.divisor  = count_reg;
                    state_next       = ST_AVG_X;
                end
            end
            ST_AVG_X:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DVD_W'(mag_y);
                    div_req.divisor  = count_reg;
                    state_next       = ST_AVG_Y;
                end
            end
            ST_AVG_Y:
            begin
                // done is a single-cycle pulse, the average is kept on it
                if (div_rsp.done)
                begin
                    state_next = ST_SUM_OUT;
                end
            end
            ST_SUM_OUT:
            begin
                // both averages are final here
                if (slot_free)
                begin
                    load_shared = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_we)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (load_port || load_shared)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // frame accumulators and averages
    // ---------------------------------------------------------------------
    logic avg_y_done;
    assign avg_y_done = (state_reg == ST_AVG_Y) && div_rsp.done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            or_held_reg     <= '0;
            or_pressed_reg  <= '0;
            or_released_reg <= '0;
            or_dir_reg      <= '0;
            or_dir_p_reg    <= '0;
            or_dir_r_reg    <= '0;
            or_pulse_reg    <= 1'b0;
            sum_x_reg       <= '0;
            sum_y_reg       <= '0;
            count_reg       <= '0;
            avg_x_reg       <= '0;
            avg_y_reg       <= '0;
        end
        else if (load_shared)
        begin
            or_held_reg     <= '0;
            or_pressed_reg  <= '0;
            or_released_reg <= '0;
            or_dir_reg      <= '0;
            or_dir_p_reg    <= '0;
            or_dir_r_reg    <= '0;
            or_pulse_reg    <= 1'b0;
            sum_x_reg       <= '0;
            sum_y_reg       <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (load_port && live_reg)
            begin
                or_held_reg     <= or_held_reg | held_reg;
                or_pressed_reg  <= or_pressed_reg | pressed_reg;
                or_released_reg <= or_released_reg | released_reg;
                or_dir_reg      <= or_dir_reg | dir_reg;
                or_dir_p_reg    <= or_dir_p_reg | dir_p_reg;
                or_dir_r_reg    <= or_dir_r_reg | dir_r_reg;
                or_pulse_reg    <= or_pulse_reg | pulse_reg;
                sum_x_reg <= sum_x_reg + {{(SUM_W-AXIS_W){ax_reg[AXIS_W-1]}}, ax_reg};
                sum_y_reg <= sum_y_reg + {{(SUM_W-AXIS_W){ay_reg[AXIS_W-1]}}, ay_reg};
                count_reg <= count_reg + 1'b1;
            end
            if ((state_reg == ST_AVG_X) && div_rsp.done)
            begin
                avg_x_reg <= sum_x_reg[SUM_W-1] ? (~quo8 + 1'b1) : quo8;
            end
            if (avg_y_done)
            begin
                avg_y_reg <= sum_y_reg[SUM_W-1] ? (~quo8 + 1'b1) : quo8;
            end
        end
    end

    // ---------------------------------------------------------------------
    // payload registers
    // ---------------------------------------------------------------------
    logic [OUT_DW-1:0] port_word;
    logic [OUT_DW-1:0] dead_word;
    logic [OUT_DW-1:0] shared_word;

    always_comb
    begin
        port_word = {1'b0, ay_reg, ax_reg, pulse_reg, dir_r_reg, dir_p_reg,
                     dir_reg, released_reg, pressed_reg, held_reg, port_reg};
        dead_word = {1'b1, 77'd0, port_reg};
        shared_word = {1'b0, avg_y_reg, avg_x_reg, or_pulse_reg, or_dir_r_reg,
                       or_dir_p_reg, or_dir_reg, or_released_reg,
                       or_pressed_reg, or_held_reg, 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            port_reg <= s_axis_tdata[1:0];
            raw_reg  <= s_axis_tdata[17:2];
            ax_reg   <= s_axis_tdata[25:18];
            ay_reg   <= s_axis_tdata[33:26];
            err_reg  <= s_axis_tuser;
            last_reg <= s_axis_tlast;
        end
        if (state_reg == ST_LOOK)
        begin
            entry_reg     <= entry;
            live_reg      <= live;
            held_reg      <= held;
            pressed_reg   <= (held ^ entry.buttons) & held;
            released_reg  <= (held ^ entry.buttons) & entry.buttons;
            dir_reg       <= dir;
            dir_p_reg     <= (dir ^ entry.dir) & dir;
            dir_r_reg     <= (dir ^ entry.dir) & entry.dir;
            hold_cond_reg <= hold_cond;
            cnt_reg       <= entry.hold + 1'b1;
        end
        if (state_reg == ST_EVAL)
        begin
            pulse_reg <= 1'b0;
        end
        else if ((state_reg == ST_MOD) && div_rsp.done)
        begin
            pulse_reg <= (div_rsp.remainder == '0);
        end
        if (load_port)
        begin
            out_data_reg <= live_reg ? port_word : dead_word;
            out_user_reg <= 1'b0;
        end
        else if (load_shared)
        begin
            out_data_reg <= shared_word;
            out_user_reg <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/gea_checker.sv =====
// ---------------------------------------------------------------------------
// gea_checker
// port-level checks on the result stream, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gea_checker
    import gea_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [OUT_DW-1:0] m_axis_tdata,
    input wire logic              m_axis_tuser
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // combined result carries no port number and no disconnect flag
    a_shared_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[1:0] == 2'b00) && !m_axis_tdata[79])
        else $error("combined result with port or disconnect set");

    // disconnected port reports nothing but its flag and number
    a_dead_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[79] |->
            !m_axis_tuser && (m_axis_tdata[78:2] == '0))
        else $error("disconnected result carries data");

    // press edges are always a subset of held bits
    a_press_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ((m_axis_tdata[33:18] & ~m_axis_tdata[17:2]) == '0)
            && ((m_axis_tdata[57:54] & ~m_axis_tdata[53:50]) == '0))
        else $error("press edge without held bit");

endmodule

bind gamepad_edge_and_autorepeat gea_checker u_gea_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== test/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the gamepad edge and auto-repeat block: poll
// samples go in on the slave stream, every result on the master stream is
// compared field by field against an in-bench prediction of the per-port
// edges, direction bits, repeat pulses, disconnect latching and frame summary
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import gea_pkg::*;

    localparam int NUM_PORTS   = PORTS_DEFAULT;
    // a sample plus one divider pass plus the two averaging passes, with margin
    localparam int TAIL_CYCLES = 160;
    localparam int LIMIT       = 1_000_000;

    // direction encoding of the result
    localparam logic [DIR_W-1:0] DIR_LEFT  = 4'b0001;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 4'b0010;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 4'b0100;
    localparam logic [DIR_W-1:0] DIR_UP    = 4'b1000;

    // one result as seen on the master stream
    typedef struct packed {
        logic                     is_shared;
        logic [PORT_W-1:0]        port;
        logic [BTN_W-1:0]         held;
        logic [BTN_W-1:0]         pressed;
        logic [BTN_W-1:0]         released;
        logic [DIR_W-1:0]         dir;
        logic [DIR_W-1:0]         dir_pressed;
        logic [DIR_W-1:0]         dir_released;
        logic                     pulse;
        logic signed [AXIS_W-1:0] stick_x;
        logic signed [AXIS_W-1:0] stick_y;
        logic                     disc;
    } pad_result_t;

    // clock, reset and block ports, the bench-driven ones known from time zero
    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_DW-1:0]  s_axis_tdata  = '0;
    logic              s_axis_tuser  = 1'b0;
    logic              s_axis_tlast  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b1;
    logic [OUT_DW-1:0] m_axis_tdata;
    logic              m_axis_tuser;
    logic              cfg_we        = 1'b0;
    logic [1:0]        cfg_index     = CFG_BUTTON_MASK;
    logic [CFG_W-1:0]  cfg_data      = '0;

    // predicted register values, tracking every write
    logic [BTN_W-1:0] reg_mask   = MASK_RST;
    logic [THR_W-1:0] reg_thr    = THR_RST;
    logic [CFG_W-1:0] reg_delay  = DELAY_RST;
    logic [CFG_W-1:0] reg_period = PERIOD_RST;

    // predicted per-port state
    bit              port_dead [NUM_PORTS];
    bit [BTN_W-1:0]  prev_btn  [NUM_PORTS];
    bit [DIR_W-1:0]  prev_dir  [NUM_PORTS];
    bit [HOLD_W-1:0] hold_cnt  [NUM_PORTS];

    // predicted frame accumulators and last averages
    bit [BTN_W-1:0] or_held, or_pressed, or_released;
    bit [DIR_W-1:0] or_dir, or_dir_pressed, or_dir_released;
    bit             or_pulse;
    int             sum_x, sum_y, active_cnt, avg_x, avg_y;

    // results predicted but not yet seen, oldest first
    pad_result_t pending_pad_results [$];

    // what was last sent per port, so random traffic can hold a sample steady
    logic [BTN_W-1:0]         last_raw [NUM_PORTS];
    logic signed [AXIS_W-1:0] last_x   [NUM_PORTS];
    logic signed [AXIS_W-1:0] last_y   [NUM_PORTS];

    // idling controls and run statistics
    bit gaps_on  = 1'b0;
    bit stall_on = 1'b0;
    int stall_left   = 0;
    int stall_roll   = 0;
    int err_cnt      = 0;
    int items_sent   = 0;
    int frames_sent  = 0;
    int results_seen = 0;
    int pulses_seen  = 0;
    int dead_seen    = 0;
    int config_count = 0;
    int cycle_cnt    = 0;

    gamepad_edge_and_autorepeat #(
        .PORTS (NUM_PORTS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------------
    // prediction: one accepted poll sample gives one per-port result and,
    // when it closes a frame, the combined result
    // ---------------------------------------------------------------------
    task automatic derive_pad_results(input logic [PORT_W-1:0] port, input bit err,
                                      input logic [BTN_W-1:0] raw, input int ax,
                                      input int ay, input bit last);
        pad_result_t      r;
        logic [BTN_W-1:0] held, prev, bdiff;
        logic [DIR_W-1:0] dir, pdir, ddiff;
        logic [31:0]      cnt, per;
        int               thr;
        r = '0;
        r.port = port;
        if (port_dead[port] || err)
        begin
            // latched for good; nothing else reported and nothing accumulated
            port_dead[port] = 1'b1;
            r.disc = 1'b1;
        end
        else
        begin
            thr   = reg_thr;
            held  = raw & reg_mask;
            prev  = prev_btn[port];
            bdiff = prev ^ held;
            pdir  = prev_dir[port];
            dir   = '0;
            // symmetric threshold, strictly beyond it counts as held
            if (ax < -thr)
                dir = DIR_LEFT;
            else if (ax > thr)
                dir = DIR_RIGHT;
            if (ay < -thr)
                dir |= DIR_DOWN;
            else if (ay > thr)
                dir |= DIR_UP;
            ddiff = pdir ^ dir;
            // repeat counting only for non-idle input that has not changed
            if ((held != 0 || dir != 0) && held == prev && dir == pdir)
            begin
                cnt = hold_cnt[port] + 32'd1;
                per = (reg_period == 0) ? 32'd1 : 32'(reg_period);
                hold_cnt[port] = cnt;
                r.pulse = (cnt >= 32'(reg_delay)) && (((cnt - 32'(reg_delay)) % per) == 0);
            end
            else
                hold_cnt[port] = '0;
            prev_btn[port] = held;
            prev_dir[port] = dir;
            r.held         = held;
            r.pressed      = bdiff & held;
            r.released     = bdiff & prev;
            r.dir          = dir;
            r.dir_pressed  = ddiff & dir;
            r.dir_released = ddiff & pdir;
            r.stick_x      = 8'(ax);
            r.stick_y      = 8'(ay);
            or_held         |= r.held;
            or_pressed      |= r.pressed;
            or_released     |= r.released;
            or_dir          |= r.dir;
            or_dir_pressed  |= r.dir_pressed;
            or_dir_released |= r.dir_released;
            or_pulse        |= r.pulse;
            sum_x += ax;
            sum_y += ay;
            active_cnt++;
        end
        pending_pad_results.push_back(r);
        if (last)
        begin
            // frame summary; with no active port the old averages stand
            if (active_cnt != 0)
            begin
                avg_x = sum_x / active_cnt;
                avg_y = sum_y / active_cnt;
            end
            r = '0;
            r.is_shared    = 1'b1;
            r.held         = or_held;
            r.pressed      = or_pressed;
            r.released     = or_released;
            r.dir          = or_dir;
            r.dir_pressed  = or_dir_pressed;
            r.dir_released = or_dir_released;
            r.pulse        = or_pulse;
            r.stick_x      = 8'(avg_x);
            r.stick_y      = 8'(avg_y);
            pending_pad_results.push_back(r);
            or_held = '0;
            or_pressed = '0;
            or_released = '0;
            or_dir = '0;
            or_dir_pressed = '0;
            or_dir_released = '0;
            or_pulse = 1'b0;
            sum_x = 0;
            sum_y = 0;
            active_cnt = 0;
        end
    endtask

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------

    // sender gap: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (!gaps_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // stick value biased to the extremes and to either side of the threshold
    function automatic logic signed [AXIS_W-1:0] pick_axis();
        int t;
        t = reg_thr;
        case ($urandom_range(0, 6))
            0:       return 8'h80;
            1:       return 8'h7F;
            2:       return 8'(t + $urandom_range(0, 1));
            3:       return 8'(-t - $urandom_range(0, 1));
            4:       return 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [BTN_W-1:0] pick_buttons(input logic [BTN_W-1:0] prev);
        case ($urandom_range(0, 4))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return prev ^ (16'd1 << $urandom_range(0, 15));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // one poll sample transaction; tvalid stays high into the next sample when
    // there is no gap, and the prediction is made at the accepting edge
    task automatic send_poll(input logic [PORT_W-1:0] port, input bit err,
                             input logic [BTN_W-1:0] raw, input logic signed [AXIS_W-1:0] ax,
                             input logic signed [AXIS_W-1:0] ay, input bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {6'd0, ay, ax, raw, port};
        s_axis_tuser  <= err;
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        derive_pad_results(port, err, raw, ax, ay, last);
        items_sent++;
        if (last)
            frames_sent++;
        last_raw[port] = raw;
        last_x[port]   = ax;
        last_y[port]   = ay;
    endtask

    // sender pauses until every predicted result has arrived, then lets the
    // block finish any divider pass still running
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_pad_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // registers change only with the block idle
    task automatic write_all(input logic [BTN_W-1:0] mask, input logic [THR_W-1:0] thr,
                             input logic [CFG_W-1:0] delay, input logic [CFG_W-1:0] period);
        settle_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BUTTON_MASK;
        cfg_data  <= mask;
        @(posedge clk);
        cfg_index <= CFG_STICK_THRESHOLD;
        cfg_data  <= {9'd0, thr};
        @(posedge clk);
        cfg_index <= CFG_REPEAT_DELAY;
        cfg_data  <= delay;
        @(posedge clk);
        cfg_index <= CFG_REPEAT_PERIOD;
        cfg_data  <= period;
        @(posedge clk);
        cfg_we    <= 1'b0;
        reg_mask   = mask;
        reg_thr    = thr;
        reg_delay  = delay;
        reg_period = period;
        config_count++;
    endtask

    // the same sample on one port n times, frames closed at random
    task automatic hold_run(input logic [PORT_W-1:0] port, input logic [BTN_W-1:0] raw,
                            input logic signed [AXIS_W-1:0] ax,
                            input logic signed [AXIS_W-1:0] ay, input int n);
        int i;
        for (i = 0; i < n; i++)
            send_poll(port, 1'b0, raw, ax, ay, (i == n - 1) || ($urandom_range(0, 1) == 1));
    endtask

    // well-formed frames of one to four samples, mostly holding each port
    // steady so the repeat counters climb, the rest fresh random content
    task automatic run_random_frames(input int n_items);
        int                       sent, len, i;
        logic [PORT_W-1:0]        p;
        logic [BTN_W-1:0]         raw;
        logic signed [AXIS_W-1:0] ax, ay;
        sent = 0;
        while (sent < n_items)
        begin
            len = $urandom_range(1, 4);
            if (len > n_items - sent)
                len = n_items - sent;
            for (i = 0; i < len; i++)
            begin
                p = $urandom_range(0, NUM_PORTS - 1);
                if ($urandom_range(0, 9) < 7)
                begin
                    raw = last_raw[p];
                    ax  = last_x[p];
                    ay  = last_y[p];
                end
                else
                begin
                    raw = pick_buttons(last_raw[p]);
                    ax  = pick_axis();
                    ay  = pick_axis();
                end
                send_poll(p, 1'b0, raw, ax, ay, i == len - 1);
            end
            sent += len;
        end
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // reset register values, field extremes, threshold edges, edges across
    // frames, the same port twice in a frame, averages truncated toward zero
    task automatic test_edges_and_averages();
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        send_poll(2'd0, 1'b0, 16'h0000, -128,  127, 1'b0);
        send_poll(2'd1, 1'b0, 16'hFFFF,  127, -128, 1'b0);
        send_poll(2'd2, 1'b0, 16'h8001,   50,  -50, 1'b0);
        send_poll(2'd3, 1'b0, 16'h5A5A,   51,  -51, 1'b1);
        send_poll(2'd1, 1'b0, 16'h0000,    0,    0, 1'b0);
        send_poll(2'd1, 1'b0, 16'h0F0F,  -51,   51, 1'b0);
        send_poll(2'd0, 1'b0, 16'h0001,   -3,   -2, 1'b1);
        send_poll(2'd3, 1'b0, 16'h5A5A,   51,  -51, 1'b1);
        send_poll(2'd0, 1'b0, 16'hFFFF,   -1,   -1, 1'b0);
        send_poll(2'd2, 1'b0, 16'h0000,  -49,   49, 1'b0);
        send_poll(2'd3, 1'b0, 16'h5A5A,   51,  -51, 1'b1);
    endtask

    // repeat pulse timing: zero delay with unit period, a masked-out idle
    // input that must not count, direction-only holding, longer delays
    task automatic test_autorepeat();
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        write_all(16'hFFFF, 7'd50, 16'd0, 16'd1);
        hold_run(2'd0, 16'h0001,    0,   0,  6);
        hold_run(2'd1, 16'h0000, -128,   0,  5);
        hold_run(2'd2, 16'h0000,    0,   0,  3);
        write_all(16'h00FF, 7'd10, 16'd3, 16'd4);
        hold_run(2'd3, 16'h0100,    0,   0,  4);
        hold_run(2'd3, 16'h0180,    0, 127, 14);
        write_all(16'hFFFF, 7'd50, 16'd1, 16'd2);
        hold_run(2'd0, 16'h8000,   60, -60,  9);
    endtask

    // random frames over a spread of settings, the extremes among them and a
    // zero period; idling switched off on one side in some phases
    task automatic test_random_traffic();
        int ph;
        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_all(16'hFFFF, 7'd0, 16'd4, 16'd3);
                1: write_all(16'h0000, 7'd127, 16'd0, 16'd1);
                2: write_all(16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)),
                             16'hFFFF, 16'hFFFF);
                3: write_all(16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)),
                             16'($urandom_range(0, 12)), 16'($urandom_range(1, 6)));
                4: write_all(16'hFFFF, 7'd50, 16'd2, 16'd0);
                default: write_all(16'($urandom_range(0, 65535)), 7'($urandom_range(0, 60)),
                                   16'($urandom_range(0, 6)), 16'($urandom_range(1, 4)));
            endcase
            gaps_on  = (ph != 2);
            stall_on = (ph != 4);
            run_random_frames(100);
        end
    endtask

    // disconnect latching: an error kills a port for good, dead ports add
    // nothing to the frame, a frame of dead ports only repeats the averages;
    // kept last since nothing but reset revives a port
    task automatic test_disconnect();
        int i;
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        send_poll(2'd2, 1'b1, 16'hA5A5,  100,  -90, 1'b0);
        send_poll(2'd2, 1'b0, 16'h1234,   10,   10, 1'b0);
        send_poll(2'd0, 1'b0, 16'h0003,  -60,    5, 1'b1);
        send_poll(2'd0, 1'b1, 16'hFFFF,  127,  127, 1'b0);
        send_poll(2'd1, 1'b0, 16'h0010,   -7,    0, 1'b1);
        send_poll(2'd1, 1'b1, 16'h0000,    0,    0, 1'b0);
        send_poll(2'd3, 1'b1, 16'hFFFF, -128, -128, 1'b1);
        for (i = 0; i < 12; i++)
            send_poll(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      16'($urandom_range(0, 65535)), pick_axis(), pick_axis(),
                      (i == 11) || ($urandom_range(0, 2) == 0));
    endtask

    // ---------------------------------------------------------------------
    // receiver back-pressure: mostly ready, short stalls, a few long ones
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!stall_on)
            m_axis_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 15)
            begin
                stall_left = $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end
            else if (stall_roll < 17)
            begin
                stall_left = $urandom_range(10, 40);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // result checking against the oldest prediction
    // ---------------------------------------------------------------------
    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        pad_result_t got;
        pad_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.is_shared    = m_axis_tuser;
            got.port         = m_axis_tdata[1:0];
            got.held         = m_axis_tdata[17:2];
            got.pressed      = m_axis_tdata[33:18];
            got.released     = m_axis_tdata[49:34];
            got.dir          = m_axis_tdata[53:50];
            got.dir_pressed  = m_axis_tdata[57:54];
            got.dir_released = m_axis_tdata[61:58];
            got.pulse        = m_axis_tdata[62];
            got.stick_x      = m_axis_tdata[70:63];
            got.stick_y      = m_axis_tdata[78:71];
            got.disc         = m_axis_tdata[79];
            results_seen++;
            if (pending_pad_results.size() == 0)
            begin
                $error("unexpected result transaction: is_shared %0d port %0d",
                       got.is_shared, got.port);
                err_cnt++;
            end
            else
            begin
                want = pending_pad_results.pop_front();
                check_field("is_shared",          want.is_shared,    got.is_shared);
                check_field("port_out",           want.port,         got.port);
                check_field("held_buttons",       want.held,         got.held);
                check_field("pressed_buttons",    want.pressed,      got.pressed);
                check_field("released_buttons",   want.released,     got.released);
                check_field("direction",          want.dir,          got.dir);
                check_field("direction_pressed",  want.dir_pressed,  got.dir_pressed);
                check_field("direction_released", want.dir_released, got.dir_released);
                check_field("repeat_pulse",       want.pulse,        got.pulse);
                check_field("stick_x_out",        want.stick_x,      got.stick_x);
                check_field("stick_y_out",        want.stick_y,      got.stick_y);
                check_field("disconnected",       want.disc,         got.disc);
                if (want.pulse && !want.is_shared)
                    pulses_seen++;
                if (want.disc)
                    dead_seen++;
            end
        end
    end

    // watchdog on total run length
    initial
    begin
        while (cycle_cnt < LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edges_and_averages();
        test_autorepeat();
        test_random_traffic();
        test_disconnect();
        settle_idle();
        $display("summary: %0d poll samples in %0d frames across %0d register settings",
                 items_sent, frames_sent, config_count);
        $display("summary: %0d results checked, %0d repeat pulses, %0d disconnect reports",
                 results_seen, pulses_seen, dead_seen);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== gamepad_edge_and_autorepeat.f =====
rtl/core/gea_pkg.sv
rtl/core/gea_ram.sv
rtl/core/gea_divider.sv
rtl/core/gamepad_edge_and_autorepeat.sv
rtl/core/gea_checker.sv
test/tb.sv
